// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, skipped while reset is held.
`define MTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/mts_pkg.sv =====
package mts_pkg;

  localparam int unsigned WORD_W = 32;
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = 32'sh7FFF_FFFF;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_PUSH_FULL  = 2'd1,
    ERR_POP_EMPTY  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

endpackage

// ===== design/mts_ram.sv =====
module mts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/min_tracking_stack_unit.sv =====
// Min-tracking stack: LIFO of signed 32-bit words that also reports its minimum.
// Input channel (in_valid/in_ready): in_mode 0 pushes in_value, 1 pops the top.
// Result channel (out_valid/out_ready): one result item per input item with the
// top entry, the smallest held entry (both 0x7FFFFFFF when empty), an empty
// flag and an error code (1 push on full, 2 pop on empty; both leave the stack
// unchanged).
// Entries live in two single-port-write RAMs, one for data and one for the
// running minima; the current top and minimum are kept in registers.
// Sequencing: a push result is registered from S_DONE after acceptance; a pop
// first passes through S_READ, the extra state being the RAM read of the entry below.
// Items are handled one at a time: a new item is accepted only in S_IDLE, once
// the previous result has been loaded into the output register.
// A new item may be taken while the previous result still waits on out_ready;
// the block then holds its next result until the output register frees up.
// Reset clears the counts and handshake state; the RAMs need no clearing, since
// only written entries are ever read.
module min_tracking_stack_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic signed [mts_pkg::WORD_W-1:0]   in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mts_pkg::WORD_W-1:0]   out_top_value,
  output logic signed [mts_pkg::WORD_W-1:0]   out_min_value,
  output logic                                out_is_empty,
  output logic [1:0]                          out_error_code
);

  import mts_pkg::*;

  `include "assert_macros.svh"

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            data_count_r, data_count_nxt;
  logic [CW-1:0]            min_count_r, min_count_nxt;
  logic signed [WORD_W-1:0] top_data_r, top_data_nxt;
  logic signed [WORD_W-1:0] top_min_r, top_min_nxt;
  logic                     min_pop_r, min_pop_nxt;
  err_t                     err_r, err_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0] out_top_r, out_top_nxt;
  logic signed [WORD_W-1:0] out_min_r, out_min_nxt;
  logic                     out_empty_r, out_empty_nxt;
  err_t                     out_err_r, out_err_nxt;

  logic                     data_we, min_we;
  logic [AW-1:0]            data_waddr, min_waddr, data_raddr, min_raddr;
  logic [WORD_W-1:0]        data_rdata, min_rdata;
  logic [CW-1:0]            data_sub2, min_sub2;
  logic                     full, pop_min;

  assign full       = (data_count_r == CW'(STACK_DEPTH));
  assign data_sub2  = data_count_r - CW'(2);
  assign min_sub2   = min_count_r - CW'(2);
  assign data_raddr = data_sub2[AW-1:0];
  assign min_raddr  = min_sub2[AW-1:0];
  assign data_waddr = data_count_r[AW-1:0];
  assign min_waddr  = min_count_r[AW-1:0];
  assign pop_min    = (min_count_r != '0) && (top_data_r <= top_min_r);

  assign in_ready = (state_r == S_IDLE);

  mts_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (in_value),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  mts_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (min_waddr),
    .wdata (in_value),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    data_count_nxt = data_count_r;
    min_count_nxt  = min_count_r;
    top_data_nxt   = top_data_r;
    top_min_nxt    = top_min_r;
    min_pop_nxt    = min_pop_r;
    err_nxt        = err_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_top_nxt    = out_top_r;
    out_min_nxt    = out_min_r;
    out_empty_nxt  = out_empty_r;
    out_err_nxt    = out_err_r;
    data_we        = 1'b0;
    min_we         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          err_nxt     = ERR_NONE;
          min_pop_nxt = 1'b0;
          if (op_t'(in_mode) == OP_PUSH) begin
            state_nxt = S_DONE;
            if (full) begin
              err_nxt = ERR_PUSH_FULL;
            end else begin
              data_we        = 1'b1;
              top_data_nxt   = in_value;
              data_count_nxt = data_count_r + CW'(1);
              if ((min_count_r == '0) || (in_value <= top_min_r)) begin
                min_we        = 1'b1;
                top_min_nxt   = in_value;
                min_count_nxt = min_count_r + CW'(1);
              end
            end
          end else begin
            if (data_count_r == '0) begin
              err_nxt   = ERR_POP_EMPTY;
              state_nxt = S_DONE;
            end else begin
              data_count_nxt = data_count_r - CW'(1);
              min_pop_nxt    = pop_min;
              if (pop_min) begin
                min_count_nxt = min_count_r - CW'(1);
              end
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        if (data_count_r != '0) begin
          top_data_nxt = data_rdata;
        end
        if (min_pop_r && (min_count_r != '0)) begin
          top_min_nxt = min_rdata;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = (data_count_r != '0) ? top_data_r : EMPTY_WORD;
          out_min_nxt   = (min_count_r != '0) ? top_min_r : EMPTY_WORD;
          out_empty_nxt = (data_count_r == '0);
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      data_count_r <= '0;
      min_count_r  <= '0;
      min_pop_r    <= 1'b0;
      err_r        <= ERR_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      data_count_r <= data_count_nxt;
      min_count_r  <= min_count_nxt;
      min_pop_r    <= min_pop_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_data_r  <= top_data_nxt;
    top_min_r   <= top_min_nxt;
    out_top_r   <= out_top_nxt;
    out_min_r   <= out_min_nxt;
    out_empty_r <= out_empty_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_top_value  = out_top_r;
  assign out_min_value  = out_min_r;
  assign out_is_empty   = out_empty_r;
  assign out_error_code = out_err_r;

  `MTS_ASSERT(a_min_le_data, min_count_r <= data_count_r, "min count above data count")
  `MTS_ASSERT(a_count_bound, data_count_r <= CW'(STACK_DEPTH), "data count above depth")
  `MTS_ASSERT(a_read_after_idle, (state_r == S_READ) |-> ($past(state_r) == S_IDLE), "bad read entry")
  `MTS_ASSERT(a_pop_empty_flag, (out_valid_r && (out_err_r == ERR_POP_EMPTY)) |-> out_empty_r, "pop error on non-empty")

endmodule
